FILE: design/mf2d_pkg.sv
// Shared constants, payload types and window types of the RGB median filter.
package mf2d_pkg;

    localparam int MAX_RADIUS = 2;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int RAD_W    = 2;
    localparam int WID_W    = 11;
    localparam int HGT_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int LS_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int WORD_W   = LS_ROWS * PIX_W;
    localparam int SLOT_W   = $clog2(LS_ROWS);
    localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
    localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
    localparam int COLQ     = 2 * MAX_RADIUS;
    localparam int CQ_W     = $clog2(WIN_SIDE);
    localparam int RANK_W   = $clog2(WIN_N);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT) + 1;
    localparam int POS_W    = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
    localparam int LAG_W    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic            is_flush;
        logic [CH_W-1:0] in_ch2;
        logic [CH_W-1:0] in_ch1;
        logic [CH_W-1:0] in_ch0;
    } in_item_t;

    typedef struct packed {
        logic            end_of_frame;
        logic [CH_W-1:0] out_ch2;
        logic [CH_W-1:0] out_ch1;
        logic [CH_W-1:0] out_ch0;
    } out_item_t;

    typedef logic [WIN_N-1:0][CH_W-1:0] win_t;

endpackage

FILE: design/median_filter_2d_rgb.sv
// Top level of the streaming 2-D median filter for three-channel 8-bit pixels.

// Pixels enter in raster order, one transaction per clock while item_ready is high,
// and each result is the per-channel median of the (2R+1)x(2R+1) square of original
// pixels centered on it; pixels within R of an edge pass through unchanged. A result
// leaves with the transaction that brings the pixel R rows and R columns later, so
// after the last pixel of a frame the user sends R*W+R flush transactions (or pixels
// of nothing) to drain it; a flush sent before the frame is complete is taken and
// ignored. The sustained rate is one transaction per clock while the skid entry is
// not full, set by the single line-store memory: each column of the store holds all
// six recent rows in one word, read on acceptance and written back when the item
// leaves stage A, with forwarding when the same column comes back at once. After
// any register write the input is held off while the frame size product settles;
// any write to a listed register restarts the frame.
module median_filter_2d_rgb
    import mf2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        logic             emit;
        logic             eof;
        logic             border;
        logic [PIX_W-1:0] center;
    } ctrl_t;

    // Configuration registers and derived frame constants.
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [WID_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic             cfg_hit;
    logic [RAD_W-1:0] eff_r_c, eff_r_reg;
    logic [WID_W-1:0] eff_w_c, eff_w_reg;
    logic [HGT_W-1:0] eff_h_c, eff_h_reg;
    logic [HGT_W+WID_W-1:0] total_c;
    logic [RAD_W+WID_W:0]   lag_c;
    logic [POS_W-1:0] total_reg;
    logic [LAG_W-1:0] lag_reg;
    logic             settle_reg;

    // Stream position counters.
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic [POS_W-1:0]  in_pos_reg, in_pos_next, out_pos_reg, out_pos_next;

    logic adv, accept, do_write, drop, enter;
    logic emit_c, eof_c, border_c;
    logic [WID_W:0] col_inc;
    logic [WID_W:0] out_col_inc;

    // Line store: one word per column, six row slots of one pixel each.
    logic [WORD_W-1:0] line_mem [MAX_WIDTH];
    logic [WORD_W-1:0] rdata_reg;

    // Read-modify-write stage.
    logic              a_valid_reg;
    logic [COL_W-1:0]  a_addr_reg;
    logic [PIX_W-1:0]  a_pix_reg;
    logic              a_wr_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic              a_emit_reg, a_eof_reg, a_border_reg;
    logic [SLOT_W-1:0] a_oslot_reg;
    logic              fwd_reg;
    logic [WORD_W-1:0] merged;
    logic [WORD_W-1:0] col_reg [COLQ];
    logic [WORD_W-1:0] colw [WIN_SIDE];

    // Window and control pipeline.
    win_t              win0_c, win1_c, win2_c;
    logic [WIN_N-1:0]  mask_c;
    logic [PIX_W-1:0]  center_c;
    win_t              b_win0_reg, b_win1_reg, b_win2_reg;
    logic [WIN_N-1:0]  b_mask_reg;
    logic [RANK_W-1:0] b_mid_reg;
    ctrl_t             b_ctrl_reg, c_ctrl_reg, d_ctrl_reg, e_ctrl_reg;
    logic [CH_W-1:0]   med0, med1, med2;

    // Output register with one skid entry.
    logic      out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    out_item_t out_reg, out_next, skid_reg, skid_next;
    out_item_t res_c;
    logic      arrive, out_fire;

    function automatic logic [SLOT_W-1:0] row_slot(input logic [SLOT_W-1:0] oslot,
                                                   input logic [RAD_W-1:0] r,
                                                   input int i);
        int s;
        s = int'(oslot) + LS_ROWS - int'(r) + i;
        if (s >= LS_ROWS)
        begin
            s = s - LS_ROWS;
        end
        if (s >= LS_ROWS)
        begin
            s = s - LS_ROWS;
        end
        return SLOT_W'(s);
    endfunction

    function automatic logic [RANK_W-1:0] win_mid(input logic [RAD_W-1:0] r);
        int side;
        side = 2 * int'(r) + 1;
        return RANK_W'((side * side) / 2);
    endfunction

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_comb
    begin
        radius_next = radius_reg;
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:
                begin
                    radius_next = cfg_data[RAD_W-1:0];
                    cfg_hit     = 1'b1;
                end
                REG_WIDTH:
                begin
                    width_next = cfg_data[WID_W-1:0];
                    cfg_hit    = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = cfg_data[HGT_W-1:0];
                    cfg_hit     = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Out-of-range settings saturate to the supported range.
    always_comb
    begin
        eff_r_c = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
        if (width_reg == '0)
        begin
            eff_w_c = WID_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w_c = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w_c = width_reg;
        end
        if (height_reg == '0)
        begin
            eff_h_c = HGT_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            eff_h_c = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h_c = height_reg;
        end
        total_c = eff_h_c * eff_w_c;
        lag_c   = eff_r_c * eff_w_c + (RAD_W+WID_W+1)'(eff_r_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(1);
            width_reg  <= WID_W'(640);
            height_reg <= HGT_W'(480);
            eff_r_reg  <= RAD_W'(1);
            eff_w_reg  <= WID_W'(640);
            eff_h_reg  <= HGT_W'(480);
            total_reg  <= POS_W'(640 * 480);
            lag_reg    <= LAG_W'(641);
            settle_reg <= 1'b0;
        end
        else
        begin
            radius_reg <= radius_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            eff_r_reg  <= eff_r_c;
            eff_w_reg  <= eff_w_c;
            eff_h_reg  <= eff_h_c;
            total_reg  <= POS_W'(total_c);
            lag_reg    <= LAG_W'(lag_c);
            settle_reg <= cfg_we;
        end
    end

    // ---------------------------------------------------------------------
    // Acceptance and position bookkeeping
    // ---------------------------------------------------------------------
    // The whole pipeline moves together; it halts only while the skid entry is full.
    assign adv        = !skid_valid_reg;
    assign item_ready = adv && !settle_reg;
    assign accept     = item_valid && item_ready;

    // Flushes before the frame is complete are taken and dropped.
    assign do_write = in_pos_reg < total_reg;
    assign drop     = do_write && item.is_flush;
    assign enter    = accept && !drop;

    assign emit_c = {1'b0, in_pos_reg} >= ({1'b0, out_pos_reg} + (POS_W+1)'(lag_reg));
    assign eof_c  = ({1'b0, out_pos_reg} + (POS_W+1)'(1)) >= {1'b0, total_reg};

    assign col_inc     = (WID_W+1)'(in_col_reg) + (WID_W+1)'(1);
    assign out_col_inc = (WID_W+1)'(out_col_reg) + (WID_W+1)'(1);

    always_comb
    begin
        border_c = (out_row_reg < ROW_W'(eff_r_reg)) ||
                   (out_col_reg < COL_W'(eff_r_reg)) ||
                   (((ROW_W+1)'(out_row_reg) + (ROW_W+1)'(eff_r_reg)) >=
                    (ROW_W+1)'(eff_h_reg)) ||
                   (((WID_W+1)'(out_col_reg) + (WID_W+1)'(eff_r_reg)) >=
                    (WID_W+1)'(eff_w_reg));
    end

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        in_pos_next   = in_pos_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        out_pos_next  = out_pos_reg;
        if (cfg_hit)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            in_pos_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            out_pos_next  = '0;
        end
        else if (enter)
        begin
            in_pos_next = in_pos_reg + POS_W'(1);
            if (col_inc >= (WID_W+1)'(eff_w_reg))
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + ROW_W'(1);
                in_slot_next = (int'(in_slot_reg) == LS_ROWS - 1) ? '0 :
                               in_slot_reg + SLOT_W'(1);
            end
            else
            begin
                in_col_next = COL_W'(col_inc);
            end
            if (emit_c)
            begin
                if (eof_c)
                begin
                    // Frame done: everything restarts at the origin.
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    in_pos_next   = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                    out_pos_next  = '0;
                end
                else
                begin
                    out_pos_next = out_pos_reg + POS_W'(1);
                    if (out_col_inc >= (WID_W+1)'(eff_w_reg))
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + ROW_W'(1);
                        out_slot_next = (int'(out_slot_reg) == LS_ROWS - 1) ? '0 :
                                        out_slot_reg + SLOT_W'(1);
                    end
                    else
                    begin
                        out_col_next = COL_W'(out_col_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_pos_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_pos_reg  <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            in_pos_reg   <= in_pos_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            out_pos_reg  <= out_pos_next;
        end
    end

    // ---------------------------------------------------------------------
    // Line store: read on acceptance, written back when the item leaves stage A.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= line_mem[in_col_reg];
        end
        if (a_valid_reg && adv)
        begin
            line_mem[a_addr_reg] <= merged;
        end
    end

    // A column that comes straight back (one-pixel rows) takes the word just built,
    // since the memory read in that cycle still sees the old contents.
    always_comb
    begin
        merged = fwd_reg ? col_reg[0] : rdata_reg;
        if (a_wr_reg)
        begin
            merged[a_slot_reg * PIX_W +: PIX_W] = a_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= enter;
            fwd_reg     <= enter && a_valid_reg && (a_addr_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            a_addr_reg   <= in_col_reg;
            a_pix_reg    <= {item.in_ch2, item.in_ch1, item.in_ch0};
            a_wr_reg     <= do_write;
            a_slot_reg   <= in_slot_reg;
            a_emit_reg   <= emit_c;
            a_eof_reg    <= eof_c;
            a_border_reg <= border_c;
            a_oslot_reg  <= out_slot_reg;
        end
        if (adv && a_valid_reg)
        begin
            col_reg[0] <= merged;
            for (int k = 1; k < COLQ; k++)
            begin
                col_reg[k] <= col_reg[k-1];
            end
        end
    end

    // Newest column first; the window's rightmost column is the word just merged.
    always_comb
    begin
        colw[0] = merged;
        for (int k = 1; k < WIN_SIDE; k++)
        begin
            colw[k] = col_reg[k-1];
        end
    end

    always_comb
    begin
        int                k;
        logic              used;
        logic [SLOT_W-1:0] s;
        logic [PIX_W-1:0]  px;
        for (int i = 0; i < WIN_SIDE; i++)
        begin
            for (int j = 0; j < WIN_SIDE; j++)
            begin
                used = (i <= 2 * int'(eff_r_reg)) && (j <= 2 * int'(eff_r_reg));
                k    = used ? (2 * int'(eff_r_reg) - j) : 0;
                s    = row_slot(a_oslot_reg, eff_r_reg, i);
                px   = colw[CQ_W'(k)][s * PIX_W +: PIX_W];
                win0_c[i * WIN_SIDE + j] = px[CH_W-1:0];
                win1_c[i * WIN_SIDE + j] = px[2*CH_W-1:CH_W];
                win2_c[i * WIN_SIDE + j] = px[3*CH_W-1:2*CH_W];
                mask_c[i * WIN_SIDE + j] = used;
            end
        end
        center_c = colw[CQ_W'(eff_r_reg)][a_oslot_reg * PIX_W +: PIX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
            d_ctrl_reg <= '0;
            e_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            b_ctrl_reg.emit   <= a_valid_reg && a_emit_reg;
            b_ctrl_reg.eof    <= a_eof_reg;
            b_ctrl_reg.border <= a_border_reg;
            b_ctrl_reg.center <= center_c;
            c_ctrl_reg        <= b_ctrl_reg;
            d_ctrl_reg        <= c_ctrl_reg;
            e_ctrl_reg        <= d_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_win0_reg <= win0_c;
            b_win1_reg <= win1_c;
            b_win2_reg <= win2_c;
            b_mask_reg <= mask_c;
            b_mid_reg  <= win_mid(eff_r_reg);
        end
    end

    mf2d_median u_med0 (
        .clk  (clk),
        .en   (adv),
        .win  (b_win0_reg),
        .mask (b_mask_reg),
        .mid  (b_mid_reg),
        .med  (med0)
    );

    mf2d_median u_med1 (
        .clk  (clk),
        .en   (adv),
        .win  (b_win1_reg),
        .mask (b_mask_reg),
        .mid  (b_mid_reg),
        .med  (med1)
    );

    mf2d_median u_med2 (
        .clk  (clk),
        .en   (adv),
        .win  (b_win2_reg),
        .mask (b_mask_reg),
        .mid  (b_mid_reg),
        .med  (med2)
    );

    // ---------------------------------------------------------------------
    // Output register and skid entry
    // ---------------------------------------------------------------------
    always_comb
    begin
        res_c.out_ch0      = e_ctrl_reg.border ? e_ctrl_reg.center[CH_W-1:0] : med0;
        res_c.out_ch1      = e_ctrl_reg.border ? e_ctrl_reg.center[2*CH_W-1:CH_W] : med1;
        res_c.out_ch2      = e_ctrl_reg.border ? e_ctrl_reg.center[3*CH_W-1:2*CH_W] : med2;
        res_c.end_of_frame = e_ctrl_reg.eof;
    end

    assign arrive   = adv && e_ctrl_reg.emit;
    assign out_fire = out_valid_reg && result_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res_c;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_c;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    // The skid entry only fills behind a result that is being held.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register is empty");

    // Forwarding is only ever armed for an item that sits in stage A.
    a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> a_valid_reg)
        else $error("forwarding armed with no item in stage A");

    // Output position never runs ahead of input position.
    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_pos_reg <= in_pos_reg)
        else $error("output position ahead of input position");

    // The last result of a frame returns all positions to the origin.
    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (enter && emit_c && eof_c) |=> (in_pos_reg == '0) && (out_pos_reg == '0))
        else $error("positions not cleared after end of frame");
`endif

endmodule

FILE: design/mf2d_median.sv
// Pipelined rank-select median of one color channel over the masked window.
module mf2d_median
    import mf2d_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  win_t              win,
    input  logic [WIN_N-1:0]  mask,
    input  logic [RANK_W-1:0] mid,
    output logic [CH_W-1:0]   med
);

    logic [WIN_N-1:0] lt_reg [WIN_N];
    logic [WIN_N-1:0] lt_next [WIN_N];
    win_t              v1_reg;
    win_t              v2_reg;
    logic [WIN_N-1:0]  mask1_reg;
    logic [RANK_W-1:0] mid1_reg;
    logic [WIN_N-1:0]  hit_reg;
    logic [WIN_N-1:0]  hit_next;
    logic [CH_W-1:0]   med_reg;
    logic [CH_W-1:0]   med_next;

    // An element precedes another when smaller, or equal and earlier in the window.
    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            for (int j = 0; j < WIN_N; j++)
            begin
                lt_next[i][j] = mask[j] && (i != j) &&
                                ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
            end
        end
    end

    // Rank is a two-level population count of the precedence row.
    always_comb
    begin
        logic [2:0]        part;
        logic [RANK_W-1:0] rank;
        for (int i = 0; i < WIN_N; i++)
        begin
            rank = '0;
            for (int g = 0; g < WIN_SIDE; g++)
            begin
                part = '0;
                for (int b = 0; b < WIN_SIDE; b++)
                begin
                    part = part + {2'b00, lt_reg[i][g * WIN_SIDE + b]};
                end
                rank = rank + RANK_W'(part);
            end
            hit_next[i] = mask1_reg[i] && (rank == mid1_reg);
        end
    end

    always_comb
    begin
        med_next = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            med_next = med_next | (hit_reg[i] ? v2_reg[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < WIN_N; i++)
            begin
                lt_reg[i] <= lt_next[i];
            end
            v1_reg    <= win;
            mask1_reg <= mask;
            mid1_reg  <= mid;
            hit_reg   <= hit_next;
            v2_reg    <= v1_reg;
            med_reg   <= med_next;
        end
    end

    assign med = med_reg;

endmodule
